[hw/rtl/rsd_pkg.sv]
// ----------------------------------------------------------------------------
// rsd_pkg: shared types for the descending record sorter
// Record layout, front-to-back command word and back-end status.
// ----------------------------------------------------------------------------
package rsd_pkg;

  localparam int KEY_W  = 32;
  localparam int TAG_W  = 8;
  localparam int AREA_W = 32;

  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  tag;
    logic [AREA_W-1:0] area;
  } rec_t;

  typedef struct packed {
    rec_t rec;
    logic keep;   // record fits in the store
    logic last;   // closes the set and starts the sort if any record was kept
  } cmd_t;

  typedef struct packed {
    logic sorting;
    logic emitting;
  } stat_t;

endpackage

[hw/rtl/rsd_fifo.sv]
// ----------------------------------------------------------------------------
// rsd_fifo: command queue
// Short queue that decouples the input classifier from the sort engine.
// ----------------------------------------------------------------------------
module rsd_fifo import rsd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t             slot_r [QDEPTH];
  logic [QAW-1:0]   wp_r, wp_nxt;
  logic [QAW-1:0]   rp_r, rp_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = slot_r[rp_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wp_nxt  = do_push ? wp_r + QAW'(1) : wp_r;
    rp_nxt  = do_pop  ? rp_r + QAW'(1) : rp_r;
    cnt_nxt = cnt_r + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule

[hw/rtl/rsd_front.sv]
// ----------------------------------------------------------------------------
// rsd_front: input classifier
// Accept records, mark those that overflow the store, count the set.
// ----------------------------------------------------------------------------
module rsd_front import rsd_pkg::*; #(
  parameter int MAX_RECORDS = 64,
  localparam int CW = $clog2(MAX_RECORDS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [KEY_W-1:0]  key,
  input  logic [TAG_W-1:0]  tag,
  input  logic [AREA_W-1:0] area,
  input  logic              last,
  output logic              q_push,
  output cmd_t              q_data,
  input  logic              q_full,
  output logic [CW-1:0]     fcnt
);

  logic [CW-1:0] fcnt_r, fcnt_nxt;
  logic          keep;

  assign keep   = (fcnt_r < CW'(MAX_RECORDS));
  assign full   = q_full;
  assign q_push = push;
  assign fcnt   = fcnt_r;

  always_comb begin
    q_data.rec.key  = key;
    q_data.rec.tag  = tag;
    q_data.rec.area = area;
    q_data.keep     = keep;
    q_data.last     = last;
  end

  // restart the count after the closing record, saturate at capacity
  always_comb begin
    fcnt_nxt = fcnt_r;
    if (push && !q_full) begin
      if (last) begin
        fcnt_nxt = '0;
      end else if (keep) begin
        fcnt_nxt = fcnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcnt_r <= '0;
    end else begin
      fcnt_r <= fcnt_nxt;
    end
  end

endmodule

[hw/rtl/rsd_back.sv]
// ----------------------------------------------------------------------------
// rsd_back: record store and exchange sort engine
// Write records to the store, sort descending in place, stream them out.
// ----------------------------------------------------------------------------
module rsd_back import rsd_pkg::*; #(
  parameter int MAX_RECORDS = 64,
  localparam int IW = $clog2(MAX_RECORDS),
  localparam int CW = $clog2(MAX_RECORDS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  cmd_t          q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_pop,
  output rec_t          out_rec,
  output logic          out_end,
  output stat_t         stat,
  output logic [CW-1:0] bcnt
);

  typedef enum logic [5:0] {
    ST_LOAD = 6'b000001,
    ST_HEAD = 6'b000010,
    ST_CUR  = 6'b000100,
    ST_SCAN = 6'b001000,
    ST_PUT  = 6'b010000,
    ST_EMIT = 6'b100000
  } st_t;

  st_t           st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] jd_r, jd_nxt;
  logic [CW-1:0] i_inc, jd_inc, cnt_inc;
  rec_t          cur_r, cur_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          out_v_r, out_v_nxt;
  rec_t          out_r, out_nxt;
  logic          out_end_r, out_end_nxt;

  rec_t          store [MAX_RECORDS];
  rec_t          rd_q;
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_wa, mem_ra;
  rec_t          mem_wd;

  assign i_inc     = i_r + CW'(1);
  assign jd_inc    = jd_r + CW'(1);
  assign cnt_inc   = cnt_r + CW'(q_data.keep);
  assign out_valid = out_v_r;
  assign out_rec   = out_r;
  assign out_end   = out_end_r;
  assign bcnt      = cnt_r;
  assign stat.sorting  = (st_r == ST_HEAD) || (st_r == ST_CUR) ||
                         (st_r == ST_SCAN) || (st_r == ST_PUT);
  assign stat.emitting = (st_r == ST_EMIT);

  always_comb begin
    st_nxt      = st_r;
    cnt_nxt     = cnt_r;
    i_nxt       = i_r;
    jd_nxt      = jd_r;
    cur_nxt     = cur_r;
    rd_pend_nxt = rd_pend_r;
    out_v_nxt   = out_v_r;
    out_nxt     = out_r;
    out_end_nxt = out_end_r;
    q_pop       = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = i_r[IW-1:0];
    mem_wd      = cur_r;
    mem_re      = 1'b0;
    mem_ra      = i_r[IW-1:0];

    if (out_pop && out_v_r) begin
      out_v_nxt = 1'b0;
    end

    unique case (st_r)
      ST_LOAD: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_data.keep) begin
            mem_we = 1'b1;
            mem_wa = cnt_r[IW-1:0];
            mem_wd = q_data.rec;
          end
          cnt_nxt = cnt_inc;
          if (q_data.last && (cnt_inc != '0)) begin
            i_nxt  = '0;
            st_nxt = ST_HEAD;
          end
        end
      end
      ST_HEAD: begin
        mem_re = 1'b1;
        st_nxt = ST_CUR;
      end
      ST_CUR: begin
        // hold the head record of this pass in cur_r
        cur_nxt = rd_q;
        if (i_inc < cnt_r) begin
          mem_re = 1'b1;
          mem_ra = i_inc[IW-1:0];
          jd_nxt = i_inc;
          st_nxt = ST_SCAN;
        end else begin
          st_nxt = ST_PUT;
        end
      end
      ST_SCAN: begin
        // swap when the held key is strictly smaller
        if (cur_r.key < rd_q.key) begin
          mem_we  = 1'b1;
          mem_wa  = jd_r[IW-1:0];
          mem_wd  = cur_r;
          cur_nxt = rd_q;
        end
        if (jd_inc < cnt_r) begin
          mem_re = 1'b1;
          mem_ra = jd_inc[IW-1:0];
          jd_nxt = jd_inc;
        end else begin
          st_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        mem_we = 1'b1;
        if (i_inc < cnt_r) begin
          mem_re = 1'b1;
          mem_ra = i_inc[IW-1:0];
          i_nxt  = i_inc;
          st_nxt = ST_CUR;
        end else begin
          i_nxt  = '0;
          st_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (rd_pend_r) begin
          out_nxt     = rd_q;
          out_v_nxt   = 1'b1;
          out_end_nxt = (i_inc == cnt_r);
          rd_pend_nxt = 1'b0;
          i_nxt       = i_inc;
          if (i_inc == cnt_r) begin
            cnt_nxt = '0;
            st_nxt  = ST_LOAD;
          end
        end else if (!out_v_r) begin
          mem_re      = 1'b1;
          rd_pend_nxt = 1'b1;
        end
      end
      default: begin
        st_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_LOAD;
      cnt_r     <= '0;
      i_r       <= '0;
      jd_r      <= '0;
      rd_pend_r <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      cnt_r     <= cnt_nxt;
      i_r       <= i_nxt;
      jd_r      <= jd_nxt;
      rd_pend_r <= rd_pend_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    out_r     <= out_nxt;
    out_end_r <= out_end_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= store[mem_ra];
    end
  end

endmodule

[hw/rtl/record_exchange_sort_descending.sv]
// ----------------------------------------------------------------------------
// record_exchange_sort_descending: record sorter, descending key order
// Collects a set of records, exchange-sorts them by key and streams them out.
//
//   channel  | beat moves                         | handshake
//   ---------+------------------------------------+------------------------
//   in_      | key, tag, area, final_record       | in_push / in_full
//   out_     | sorted key, tag, area, end_of_run  | out_empty / out_pop
//
// A set of N records is loaded, then sorted in place with one compare per cycle
// on the single store read port, then streamed out record by record (read,
// register, pop).
// Reset is synchronous, active low; the store needs no clearing pass.
// A four-beat queue decouples the input from the engine: input stalls only
// when that queue is full, and output stalls hold the engine during emission.
// ----------------------------------------------------------------------------
module record_exchange_sort_descending import rsd_pkg::*; #(
  parameter int MAX_RECORDS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [KEY_W-1:0]  in_population_key,
  input  logic [TAG_W-1:0]  in_record_tag,
  input  logic [AREA_W-1:0] in_area_value,
  input  logic              in_final_record,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [KEY_W-1:0]  out_sorted_key,
  output logic [TAG_W-1:0]  out_sorted_tag,
  output logic [AREA_W-1:0] out_sorted_area,
  output logic              out_end_of_run
);

  localparam int CW = $clog2(MAX_RECORDS + 1);

  // front to queue
  logic          q_push, q_full;
  cmd_t          q_wdata;
  // queue to back
  logic          q_pop, q_empty;
  cmd_t          q_rdata;
  // back status
  logic          out_valid;
  rec_t          out_rec;
  stat_t         bstat;
  logic [CW-1:0] fcnt, bcnt;

  // classify each beat: keep it if the store has room, flag the closing one
  rsd_front #(.MAX_RECORDS(MAX_RECORDS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_push),
    .full   (in_full),
    .key    (in_population_key),
    .tag    (in_record_tag),
    .area   (in_area_value),
    .last   (in_final_record),
    .q_push (q_push),
    .q_data (q_wdata),
    .q_full (q_full),
    .fcnt   (fcnt)
  );

  rsd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // store, sort in place, then stream through the output register
  rsd_back #(.MAX_RECORDS(MAX_RECORDS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_pop   (out_pop),
    .out_rec   (out_rec),
    .out_end   (out_end_of_run),
    .stat      (bstat),
    .bcnt      (bcnt)
  );

  assign out_empty       = !out_valid;
  assign out_sorted_key  = out_rec.key;
  assign out_sorted_tag  = out_rec.tag;
  assign out_sorted_area = out_rec.area;

`ifndef ASSERT_OFF
  a_front_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt <= CW'(MAX_RECORDS))
    else $error("front record count exceeds capacity");

  a_back_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    bcnt <= CW'(MAX_RECORDS))
    else $error("stored record count exceeds capacity");

  a_no_pop_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.sorting |-> !q_pop)
    else $error("queue drained while sorting");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_empty) |-> $past(bstat.emitting))
    else $error("result appeared outside emission");
`endif

endmodule
